// ===== design/dtq_pkg.sv =====
// Package for the deadline timer queue: constants, register indexes, item kinds.
// Used by all design files; no dependencies.
package dtq_pkg;
	localparam int SLOTS_DEF = 16;
	localparam logic [31:0] LEAD_RESET = 32'd50;
	localparam logic [31:0] WAIT_RESET = 32'd28633115;
	localparam logic [1:0] KIND_AT = 2'd0;
	localparam logic [1:0] KIND_AFTER = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;
	localparam logic [1:0] KIND_TICK = 2'd3;
	localparam logic REG_LEAD = 1'b0;
	localparam logic REG_WAIT = 1'b1;
endpackage

// ===== design/dtq_cmp.sv =====
// Shared 64-bit compare unit of the deadline timer queue.
// Depends on dtq_pkg.
module dtq_cmp import dtq_pkg::*; (
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        le
);
	assign le = (a <= b);
endmodule

// ===== design/deadline_timer_queue.sv =====
// Top level of the deadline timer queue: sequencer, slot tables, order queue.
// Depends on dtq_pkg and dtq_cmp.
//
// channel  dir  handshake             content
// s_axis   in   tvalid/tready         tuser: kind; tdata: slot, time_value, repeat_period
// m_axis   out  tvalid/tready         tuser: fired; tdata: fired_slot, next_wait_us; tlast
// cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A schedule does a remove walk and a sorted insert, a cancel only the remove walk;
// a tick removes each fired slot in turn and re-inserts it if periodic, all through one comparator.
// Reset clears armed flags, periods, count and time and loads the config defaults. Output stalls hold
// the sequencer; input is ready again once the last result sits in the output register.
module deadline_timer_queue import dtq_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [103:0] s_axis_tdata,  // slot[3:0], time_value[67:4], repeat_period[99:68]
	input  logic [1:0]   s_axis_tuser,  // kind[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [39:0]  m_axis_tdata,  // fired_slot[3:0], next_wait_us[35:4]
	output logic         m_axis_tuser,  // fired[0]
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FIND = 3'd1;  // search slot position to remove
	localparam logic [2:0] ST_SHL  = 3'd2;  // shift left (remove)
	localparam logic [2:0] ST_POS  = 3'd3;  // search insert position
	localparam logic [2:0] ST_SHR  = 3'd4;  // shift right, then place
	localparam logic [2:0] ST_SCAN = 3'd5;  // tick scan
	localparam logic [2:0] ST_OUT  = 3'd6;
	localparam logic [2:0] ST_WAIT = 3'd7;

	logic [2:0]  state_q;
	logic [31:0] lead_q, maxw_q;
	logic [63:0] dl_q [SLOTS];
	logic [31:0] per_q [SLOTS];
	logic [SLOTS-1:0] armed_q, done_q;
	logic [3:0]  ord_q [SLOTS];
	logic [CW-1:0] cnt_q, p_q;
	logic [63:0] now_q;
	logic [3:0]  slot_q;
	logic [63:0] tv_q;
	logic [31:0] rp_q;
	logic        ins_q, tick_q;
	logic [39:0] od_q;
	logic        ofired_q, olast_q, ovalid_q;

	logic [1:0]  in_kind;
	logic [3:0]  in_slot;
	logic [63:0] in_tv;
	logic [31:0] in_rp;
	assign in_kind = s_axis_tuser;
	assign in_slot = s_axis_tdata[3:0];
	assign in_tv   = s_axis_tdata[67:4];
	assign in_rp   = s_axis_tdata[99:68];

	logic [3:0]  ord_p;
	logic [PW-1:0] pidx, sidx;
	logic        p_in;
	logic [63:0] cmp_a, cmp_b;
	logic        cmp_le;
	logic [64:0] sum;
	logic [63:0] sat;
	logic [63:0] hd, diff;
	logic [31:0] wait_v;
	logic        out_free, out_ld;

	assign pidx = p_q[PW-1:0];
	assign p_in = (p_q < cnt_q);
	assign ord_p = ord_q[pidx];
	assign sidx = slot_q[PW-1:0];

	always_comb begin
		cmp_a = dl_q[ord_p[PW-1:0]];
		cmp_b = (state_q == ST_SCAN) ? now_q : dl_q[sidx];
	end
	dtq_cmp u_cmp (.a(cmp_a), .b(cmp_b), .le(cmp_le));

	assign sum = {1'b0, dl_q[sidx]} + {33'd0, per_q[sidx]};
	assign sat = sum[64] ? '1 : sum[63:0];

	always_comb begin
		hd = dl_q[ord_q[0][PW-1:0]];
		diff = hd - now_q;
		if (cnt_q == '0) wait_v = maxw_q;
		else if (hd <= now_q || diff <= {32'd0, lead_q}) wait_v = lead_q;
		else if (diff < {32'd0, maxw_q}) wait_v = diff[31:0];
		else wait_v = maxw_q;
	end

	assign out_free = !ovalid_q || m_axis_tready;
	assign out_ld = out_free && ((state_q == ST_OUT) ||
		((state_q == ST_SCAN) && p_in && cmp_le && !done_q[ord_p[PW-1:0]]));

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !s_axis_tvalid;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = od_q;
	assign m_axis_tuser = ofired_q;
	assign m_axis_tlast = olast_q;

	logic slot_ok;
	assign slot_ok = ({28'd0, in_slot} < SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lead_q <= LEAD_RESET;
			maxw_q <= WAIT_RESET;
			armed_q <= '0;
			done_q <= '0;
			cnt_q <= '0;
			p_q <= '0;
			now_q <= '0;
			ovalid_q <= 1'b0;
			ofired_q <= 1'b0;
			olast_q <= 1'b0;
			ins_q <= 1'b0;
			tick_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) per_q[i] <= '0;
		end else begin
			if (out_ld) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						if (cfg_index == REG_LEAD) lead_q <= cfg_data;
						else maxw_q <= cfg_data;
					end
					if (s_axis_tvalid) begin
						slot_q <= in_slot;
						rp_q <= in_rp;
						p_q <= '0;
						tick_q <= (in_kind == KIND_TICK);
						if (in_kind == KIND_TICK) begin
							now_q <= in_tv;
							done_q <= '0;
							state_q <= ST_SCAN;
						end else if (!slot_ok) begin
							state_q <= ST_OUT;
						end else begin
							tv_q <= (in_kind == KIND_AT) ? in_tv :
								(({1'b0, now_q} + {1'b0, in_tv}) > 65'h0_FFFF_FFFF_FFFF_FFFF)
								? '1 : now_q + in_tv;
							ins_q <= (in_kind != KIND_CANCEL);
							state_q <= armed_q[in_slot[PW-1:0]] ? ST_FIND :
								((in_kind != KIND_CANCEL) ? ST_WAIT : ST_OUT);
							if (in_kind == KIND_CANCEL) per_q[in_slot[PW-1:0]] <= '0;
						end
					end
				end
				ST_FIND: begin
					if (!p_in) begin
						state_q <= ST_WAIT;
					end else if (ord_p == slot_q) begin
						state_q <= ST_SHL;
					end else p_q <= p_q + 1'b1;
				end
				ST_SHL: begin
					if (p_q + 1'b1 < cnt_q) begin
						ord_q[pidx] <= ord_q[PW'(p_q + 1'b1)];
						p_q <= p_q + 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					// remove done; write the slot, then insert or finish
					p_q <= '0;
					if (tick_q) begin
						if (per_q[sidx] != '0) begin
							dl_q[sidx] <= sat;
							state_q <= ST_POS;
						end else begin
							armed_q[sidx] <= 1'b0;
							state_q <= ST_SCAN;
						end
					end else if (ins_q) begin
						dl_q[sidx] <= tv_q;
						per_q[sidx] <= rp_q;
						armed_q[sidx] <= 1'b1;
						state_q <= ST_POS;
					end else begin
						armed_q[sidx] <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_POS: begin
					if (cnt_q >= CW'(SLOTS)) begin
						state_q <= tick_q ? ST_SCAN : ST_OUT;
						p_q <= '0;
					end else if (p_in && cmp_le) p_q <= p_q + 1'b1;
					else begin
						tv_q[CW-1:0] <= cnt_q;
						state_q <= ST_SHR;
					end
				end
				ST_SHR: begin
					if (tv_q[CW-1:0] > p_q) begin
						ord_q[tv_q[PW-1:0]] <= ord_q[PW'(tv_q[CW-1:0] - 1'b1)];
						tv_q[CW-1:0] <= tv_q[CW-1:0] - 1'b1;
					end else begin
						ord_q[pidx] <= slot_q;
						cnt_q <= cnt_q + 1'b1;
						p_q <= '0;
						state_q <= tick_q ? ST_SCAN : ST_OUT;
					end
				end
				ST_SCAN: begin
					if (!p_in || !cmp_le) begin
						state_q <= ST_OUT;
					end else if (!done_q[ord_p[PW-1:0]]) begin
						if (out_free) begin
							slot_q <= ord_p;
							done_q[ord_p[PW-1:0]] <= 1'b1;
							od_q <= {36'd0, ord_p};
							ofired_q <= 1'b1;
							olast_q <= 1'b0;
							state_q <= ST_SHL;
						end
					end else p_q <= p_q + 1'b1;
				end
				ST_OUT: begin
					if (out_free) begin
						od_q <= {4'd0, wait_v, 4'd0};
						ofired_q <= 1'b0;
						olast_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
